// ===== rtl/opcode_prefix_trie_decoder_macros.svh =====
// assertion macros of the trie decoder rtl
`ifndef OPCODE_PREFIX_TRIE_DECODER_MACROS_SVH
`define OPCODE_PREFIX_TRIE_DECODER_MACROS_SVH

`ifndef SYNTHESIS

// property checked on every rising edge outside of reset
`define OPTD_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("trie decoder property violated");

// property checked on every rising edge after a reset edge has passed
`define OPTD_ASSERT_POST_RST(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        $past(rst_n) |-> prop) \
        else $error("trie decoder state check failed");

`else

`define OPTD_ASSERT(label, clk, rst_n, prop)
`define OPTD_ASSERT_POST_RST(label, clk, rst_n, prop)

`endif

`endif

// ===== rtl/optd_pkg.sv =====
// shared widths, defaults, operation codes and status codes of the opcode prefix trie decoder
package optd_pkg;

    // fixed payload widths
    localparam int OPC_W     = 32;
    localparam int OPC_IDX_W = $clog2(OPC_W);
    localparam int LEN_W     = 6;
    localparam int TAG_W     = 8;
    localparam int STATUS_W  = 3;

    // parameter defaults
    localparam int NODE_COUNT_DEF  = 256;
    localparam int OPCODE_BITS_DEF = 32;

    // operation codes
    localparam logic OP_FIND = 1'b0;
    localparam logic OP_ADD  = 1'b1;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_DONE       = 3'd0,
        ST_EMPTY      = 3'd1,
        ST_UNKNOWN    = 3'd2,
        ST_NO_HANDLER = 3'd3,
        ST_POOL_FULL  = 3'd4
    } t_status;

endpackage

// ===== rtl/optd_cmd_if.sv =====
// command channel: operation, opcode, prefix length and handler tag
interface optd_cmd_if;
    logic                          valid;
    logic                          ready;
    logic                          operation;
    logic [optd_pkg::OPC_W-1:0]    opcode;
    logic [optd_pkg::LEN_W-1:0]    prefix_length;
    logic [optd_pkg::TAG_W-1:0]    handler_tag;

    modport source (
        output valid, operation, opcode, prefix_length, handler_tag,
        input  ready
    );
    modport sink (
        input  valid, operation, opcode, prefix_length, handler_tag,
        output ready
    );
endinterface

// ===== rtl/optd_rsp_if.sv =====
// response channel: status, found tag and collision flag
interface optd_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [optd_pkg::STATUS_W-1:0] status;
    logic [optd_pkg::TAG_W-1:0]    found_tag;
    logic                          collision;

    modport source (
        output valid, status, found_tag, collision,
        input  ready
    );
    modport sink (
        input  valid, status, found_tag, collision,
        output ready
    );
endinterface

// ===== rtl/optd_ram.sv =====
// generic simple dual port ram with one write port and a registered read port
module optd_ram #(
    parameter int WIDTH = 2 * $clog2(optd_pkg::NODE_COUNT_DEF) + optd_pkg::TAG_W,
    parameter int DEPTH = optd_pkg::NODE_COUNT_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/opcode_prefix_trie_decoder.sv =====
// top level of the opcode prefix trie decoder
//
// Usage: commands arrive on i_cmd (valid/ready). A find transaction walks the
// opcode from bit OPCODE_BITS-1 downward through a binary trie held in one node
// ram and answers with the tag of the first tagged node below the root on the
// path. An add transaction walks its right-aligned prefix, allocates missing
// nodes from a pool of NODE_COUNT and stores the handler tag at the end node.
// Each command gives exactly one response transaction on o_rsp.
// Sequence: an accept step, then the walk visits each trie level in turn (the
// node ram read of a level feeds the read address of the next), then the
// result goes to the response register.
// One command is worked on at a time; i_cmd.ready is high only while idle, so
// a new command is taken at the earliest in the cycle after the response has been taken.
// The node ram needs no clearing: an add writes in full each node it allocates.
// Reset (synchronous, active low) empties the trie and frees the node pool.
// A stalled response holds in the output register until o_rsp.ready is high.
`include "opcode_prefix_trie_decoder_macros.svh"

module opcode_prefix_trie_decoder #(
    parameter int NODE_COUNT  = optd_pkg::NODE_COUNT_DEF,
    parameter int OPCODE_BITS = optd_pkg::OPCODE_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    optd_cmd_if.sink          i_cmd,
    optd_rsp_if.source        o_rsp
);

    localparam int IW     = $clog2(NODE_COUNT);
    localparam int CW     = $clog2(NODE_COUNT + 1);
    localparam int NW     = 2 * IW + optd_pkg::TAG_W;
    localparam int MAXLVL = (OPCODE_BITS > 63) ? OPCODE_BITS : 63;
    localparam int LVL_W  = $clog2(MAXLVL + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_WALK = 3'b010,
        S_RESP = 3'b100
    } t_state;

    t_state                        r_state, n_state;
    logic                          r_is_add, n_is_add;
    logic [optd_pkg::OPC_W-1:0]    r_op, n_op;
    logic [LVL_W-1:0]              r_rem, n_rem;
    logic [optd_pkg::TAG_W-1:0]    r_tag, n_tag;
    logic [IW-1:0]                 r_cur, n_cur;
    logic                          r_fresh, n_fresh;
    logic                          r_check, n_check;
    logic                          r_root, n_root;
    logic [CW-1:0]                 r_free, n_free;
    optd_pkg::t_status             r_status, n_status;
    logic [optd_pkg::TAG_W-1:0]    r_found, n_found;
    logic                          r_coll, n_coll;

    // node ram ports
    logic                          ram_wr_en;
    logic [IW-1:0]                 ram_wr_addr;
    logic [NW-1:0]                 ram_wr_data;
    logic                          ram_rd_en;
    logic [IW-1:0]                 ram_rd_addr;
    logic [NW-1:0]                 ram_rd_data;

    // current node view and walk helpers
    logic [IW-1:0]                 node_zero;
    logic [IW-1:0]                 node_one;
    logic [optd_pkg::TAG_W-1:0]    node_tag;
    logic [LVL_W-1:0]              pos;
    logic                          bit_val;
    logic [IW-1:0]                 child;
    logic [IW-1:0]                 new_idx;
    logic                          pool_full;

    optd_ram #(
        .WIDTH (NW),
        .DEPTH (NODE_COUNT)
    ) u_node_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // a freshly allocated node is all zero and not read back from the ram
    assign node_zero = r_fresh ? '0 : ram_rd_data[NW-1 -: IW];
    assign node_one  = r_fresh ? '0 : ram_rd_data[optd_pkg::TAG_W +: IW];
    assign node_tag  = r_fresh ? '0 : ram_rd_data[optd_pkg::TAG_W-1:0];

    // bit of the opcode that selects the next level
    assign pos     = r_rem - LVL_W'(1);
    assign bit_val = (pos < LVL_W'(OPCODE_BITS)) && (pos < LVL_W'(optd_pkg::OPC_W))
                     ? r_op[pos[optd_pkg::OPC_IDX_W-1:0]] : 1'b0;
    assign child     = bit_val ? node_one : node_zero;
    assign new_idx   = r_free[IW-1:0];
    assign pool_full = (r_free >= CW'(NODE_COUNT));

    // control and walk sequencing
    always_comb begin
        n_state  = r_state;
        n_is_add = r_is_add;
        n_op     = r_op;
        n_rem    = r_rem;
        n_tag    = r_tag;
        n_cur    = r_cur;
        n_fresh  = r_fresh;
        n_check  = r_check;
        n_root   = r_root;
        n_free   = r_free;
        n_status = r_status;
        n_found  = r_found;
        n_coll   = r_coll;

        ram_wr_en   = 1'b0;
        ram_wr_addr = r_cur;
        ram_wr_data = {node_zero, node_one, r_tag};
        ram_rd_en   = 1'b0;
        ram_rd_addr = '0;

        case (r_state)
            S_IDLE: begin
                if (i_cmd.valid) begin
                    n_is_add = (i_cmd.operation == optd_pkg::OP_ADD);
                    n_op     = i_cmd.opcode;
                    n_tag    = i_cmd.handler_tag;
                    n_found  = '0;
                    n_coll   = 1'b0;
                    n_check  = 1'b0;
                    n_cur    = '0;
                    if (i_cmd.operation == optd_pkg::OP_ADD) begin
                        n_rem = LVL_W'(i_cmd.prefix_length);
                        if (r_root) begin
                            ram_rd_en = 1'b1;
                            n_fresh   = 1'b0;
                            n_state   = S_WALK;
                        end else if (pool_full) begin
                            n_status = optd_pkg::ST_POOL_FULL;
                            n_state  = S_RESP;
                        end else begin
                            // root comes from the first free node
                            n_root  = 1'b1;
                            n_free  = r_free + CW'(1);
                            n_fresh = 1'b1;
                            n_state = S_WALK;
                        end
                    end else begin
                        n_rem = LVL_W'(OPCODE_BITS);
                        if (r_root) begin
                            ram_rd_en = 1'b1;
                            n_fresh   = 1'b0;
                            n_state   = S_WALK;
                        end else begin
                            n_status = optd_pkg::ST_EMPTY;
                            n_state  = S_RESP;
                        end
                    end
                end
            end

            S_WALK: begin
                if (r_is_add) begin
                    if (r_rem == '0) begin
                        // end of prefix: store the tag
                        ram_wr_en = 1'b1;
                        n_coll    = (node_zero != '0) || (node_one != '0);
                        n_status  = optd_pkg::ST_DONE;
                        n_state   = S_RESP;
                    end else if (child != '0) begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = child;
                        n_cur       = child;
                        n_fresh     = 1'b0;
                        n_rem       = r_rem - LVL_W'(1);
                    end else if (pool_full) begin
                        // a fresh node still has to land in the ram
                        ram_wr_en   = r_fresh;
                        ram_wr_data = '0;
                        n_status    = optd_pkg::ST_POOL_FULL;
                        n_state     = S_RESP;
                    end else begin
                        // link a new node into the current one
                        ram_wr_en   = 1'b1;
                        ram_wr_data = bit_val ? {node_zero, new_idx, node_tag}
                                              : {new_idx, node_one, node_tag};
                        n_cur       = new_idx;
                        n_fresh     = 1'b1;
                        n_free      = r_free + CW'(1);
                        n_rem       = r_rem - LVL_W'(1);
                    end
                end else begin
                    if (r_check && (node_tag != '0)) begin
                        n_found  = node_tag;
                        n_status = optd_pkg::ST_DONE;
                        n_state  = S_RESP;
                    end else if (r_rem == '0) begin
                        n_status = optd_pkg::ST_NO_HANDLER;
                        n_state  = S_RESP;
                    end else if (child == '0) begin
                        n_status = optd_pkg::ST_UNKNOWN;
                        n_state  = S_RESP;
                    end else begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = child;
                        n_cur       = child;
                        n_check     = 1'b1;
                        n_rem       = r_rem - LVL_W'(1);
                    end
                end
            end

            S_RESP: begin
                if (o_rsp.ready) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_root  <= 1'b0;
            r_free  <= '0;
        end else begin
            r_state <= n_state;
            r_root  <= n_root;
            r_free  <= n_free;
        end
    end

    // walk and result registers
    always_ff @(posedge i_clk) begin
        r_is_add <= n_is_add;
        r_op     <= n_op;
        r_rem    <= n_rem;
        r_tag    <= n_tag;
        r_cur    <= n_cur;
        r_fresh  <= n_fresh;
        r_check  <= n_check;
        r_status <= n_status;
        r_found  <= n_found;
        r_coll   <= n_coll;
    end

    // handshake outputs
    assign i_cmd.ready     = (r_state == S_IDLE);
    assign o_rsp.valid     = (r_state == S_RESP);
    assign o_rsp.status    = r_status;
    assign o_rsp.found_tag = r_found;
    assign o_rsp.collision = r_coll;

    // never take a command while a response is pending
    `OPTD_ASSERT(a_rsp_blocks_cmd, i_clk, i_rst_n, o_rsp.valid |-> !i_cmd.ready)
    // node pool count stays within the pool
    `OPTD_ASSERT_POST_RST(a_free_in_range, i_clk, i_rst_n, r_free <= CW'(NODE_COUNT))
    // no nodes exist without a root
    `OPTD_ASSERT_POST_RST(a_empty_no_nodes, i_clk, i_rst_n, !r_root |-> (r_free == '0))
    // a found tag only comes with a successful find
    `OPTD_ASSERT(a_tag_on_done, i_clk, i_rst_n,
        (o_rsp.valid && (o_rsp.found_tag != '0)) |-> (r_status == optd_pkg::ST_DONE && !r_is_add))
    // collision only reported by a successful add
    `OPTD_ASSERT(a_coll_on_add, i_clk, i_rst_n,
        (o_rsp.valid && o_rsp.collision) |-> (r_status == optd_pkg::ST_DONE && r_is_add))

endmodule

// ===== tb/opcode_prefix_trie_decoder_tb.sv =====
// self-checking testbench of the opcode prefix trie decoder: directed and random add and find traffic
`timescale 1ns / 100ps

module opcode_prefix_trie_decoder_tb;

    localparam int OPC_W        = optd_pkg::OPC_W;
    localparam int LEN_W        = optd_pkg::LEN_W;
    localparam int TAG_W        = optd_pkg::TAG_W;
    localparam int TRIE_NODES   = optd_pkg::NODE_COUNT_DEF;
    localparam int WORD_BITS    = optd_pkg::OPCODE_BITS_DEF;
    localparam int RANDOM_ITEMS = 900;
    localparam int DRAIN_CYCLES = 80;
    localparam int LIMIT_CYCLES = 600000;

    typedef struct packed {
        logic             operation;
        logic [OPC_W-1:0] opcode;
        logic [LEN_W-1:0] prefix_length;
        logic [TAG_W-1:0] handler_tag;
    } t_cmd_item;

    typedef struct packed {
        optd_pkg::t_status status;
        logic [TAG_W-1:0]  found_tag;
        logic              collision;
    } t_rsp_expect;

    // clock, reset and channels
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    optd_cmd_if cmd_bus ();
    optd_rsp_if rsp_bus ();

    logic             drv_valid  = 1'b0;
    logic             drv_op     = optd_pkg::OP_FIND;
    logic [OPC_W-1:0] drv_opcode = '0;
    logic [LEN_W-1:0] drv_len    = '0;
    logic [TAG_W-1:0] drv_tag    = '0;
    logic             rsp_ready_q = 1'b0;
    logic             no_idle     = 1'b0;

    assign cmd_bus.valid         = drv_valid;
    assign cmd_bus.operation     = drv_op;
    assign cmd_bus.opcode        = drv_opcode;
    assign cmd_bus.prefix_length = drv_len;
    assign cmd_bus.handler_tag   = drv_tag;
    assign rsp_bus.ready         = rsp_ready_q;

    always #10 i_clk = ~i_clk;

    opcode_prefix_trie_decoder DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_bus),
        .o_rsp   (rsp_bus)
    );

    // commands waiting to be sent, responses waiting to arrive, prefixes queued for adding
    t_cmd_item   cmd_backlog[$];
    t_rsp_expect rsp_expected[$];
    t_cmd_item   known_prefixes[$];

    // shadow copy of the trie
    logic            root_made;
    logic [7:0]      zero_kid [TRIE_NODES];
    logic [7:0]      one_kid  [TRIE_NODES];
    logic [TAG_W-1:0] tag_of  [TRIE_NODES];
    int unsigned     nodes_used;

    int unsigned n_finds, n_adds, n_collisions, n_errors, n_rsp;
    int unsigned status_seen [5];
    int unsigned wait_left, stall_left, cycles;

    function automatic int unsigned draw_pause();
        if (no_idle || $urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, 18);
    endfunction

    function automatic int unsigned grab_node();
        int unsigned idx;
        idx = nodes_used;
        zero_kid[idx] = '0;
        one_kid[idx]  = '0;
        tag_of[idx]   = '0;
        nodes_used++;
        return idx;
    endfunction

    // walk the shadow trie for one command and give its response
    function automatic t_rsp_expect trie_apply(t_cmd_item c);
        t_rsp_expect r;
        int unsigned cur, nxt, k, pos;
        logic b;
        r.status    = optd_pkg::ST_DONE;
        r.found_tag = '0;
        r.collision = 1'b0;
        cur = 0;
        if (c.operation == optd_pkg::OP_ADD) begin
            if (!root_made) begin
                if (nodes_used >= TRIE_NODES) begin
                    r.status = optd_pkg::ST_POOL_FULL;
                    return r;
                end
                void'(grab_node());
                root_made = 1'b1;
            end
            for (k = 0; k < c.prefix_length; k++) begin
                pos = c.prefix_length - 1 - k;
                b = (pos < WORD_BITS) ? c.opcode[pos] : 1'b0;
                nxt = b ? one_kid[cur] : zero_kid[cur];
                if (nxt == 0) begin
                    // pool exhausted mid-walk: nodes made so far stay
                    if (nodes_used >= TRIE_NODES) begin
                        r.status = optd_pkg::ST_POOL_FULL;
                        return r;
                    end
                    nxt = grab_node();
                    if (b)
                        one_kid[cur] = nxt[7:0];
                    else
                        zero_kid[cur] = nxt[7:0];
                end
                cur = nxt;
            end
            tag_of[cur] = c.handler_tag;
            r.collision = (one_kid[cur] != 0) || (zero_kid[cur] != 0);
        end else begin
            if (!root_made) begin
                r.status = optd_pkg::ST_EMPTY;
                return r;
            end
            // shortest tagged prefix wins, root tag is skipped
            for (k = WORD_BITS; k > 0; k--) begin
                cur = c.opcode[k-1] ? one_kid[cur] : zero_kid[cur];
                if (cur == 0) begin
                    r.status = optd_pkg::ST_UNKNOWN;
                    return r;
                end
                if (tag_of[cur] != 0) begin
                    r.found_tag = tag_of[cur];
                    return r;
                end
            end
            r.status = optd_pkg::ST_NO_HANDLER;
        end
        return r;
    endfunction

    task automatic queue_cmd(logic op, logic [OPC_W-1:0] opc, logic [LEN_W-1:0] len,
                             logic [TAG_W-1:0] tag);
        t_cmd_item c;
        c.operation     = op;
        c.opcode        = opc;
        c.prefix_length = len;
        c.handler_tag   = tag;
        cmd_backlog.push_back(c);
        if (op == optd_pkg::OP_ADD)
            known_prefixes.push_back(c);
    endtask

    function automatic logic [TAG_W-1:0] pick_tag();
        if ($urandom_range(0, 9) == 0)
            return '0;
        return TAG_W'($urandom_range(1, 255));
    endfunction

    // mostly well-formed traffic: new prefixes, re-adds, truncations, guided and random finds
    task automatic build_random(int unsigned count);
        int unsigned i, r, s, len, cut;
        t_cmd_item p;
        logic [OPC_W-1:0] opc, low;
        logic [63:0] wide;
        for (i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < 35) begin
                s = $urandom_range(0, 99);
                if (s < 40 || known_prefixes.size() == 0) begin
                    r = $urandom_range(0, 99);
                    if (r < 5)
                        len = 0;
                    else if (r < 10)
                        len = $urandom_range(33, 63);
                    else if (r < 22)
                        len = $urandom_range(9, 32);
                    else
                        len = $urandom_range(1, 8);
                    queue_cmd(optd_pkg::OP_ADD, $urandom, LEN_W'(len), pick_tag());
                end else if (s < 70) begin
                    p = known_prefixes[$urandom_range(0, known_prefixes.size() - 1)];
                    queue_cmd(optd_pkg::OP_ADD, p.opcode, p.prefix_length, pick_tag());
                end else begin
                    // a known prefix, cut or whole: a shorter cut can end on a node with children
                    p = known_prefixes[$urandom_range(0, known_prefixes.size() - 1)];
                    cut = $urandom_range(0, p.prefix_length);
                    wide = {32'd0, p.opcode} >> (p.prefix_length - cut);
                    queue_cmd(optd_pkg::OP_ADD, wide[31:0], LEN_W'(cut), pick_tag());
                end
            end else begin
                if ($urandom_range(0, 99) < 60 && known_prefixes.size() > 0) begin
                    p = known_prefixes[$urandom_range(0, known_prefixes.size() - 1)];
                    len = p.prefix_length;
                    low = $urandom;
                    if (len == 0)
                        opc = low;
                    else if (len <= 32)
                        opc = (p.opcode << (32 - len)) | (low & (32'hFFFF_FFFF >> len));
                    else begin
                        wide = {32'd0, p.opcode} >> (len - 32);
                        opc = wide[31:0];
                    end
                    if ($urandom_range(0, 4) == 0)
                        opc ^= 32'd1 << $urandom_range(0, 31);
                end else begin
                    opc = $urandom;
                end
                cmd_backlog.push_back(t_cmd_item'{optd_pkg::OP_FIND, opc, LEN_W'($urandom),
                                                  TAG_W'($urandom)});
            end
        end
    endtask

    // driver: one transaction at a time from the backlog
    always @(posedge i_clk) begin : driver
        t_cmd_item   sent;
        t_rsp_expect want;
        if (!i_rst_n) begin
            drv_valid <= 1'b0;
            wait_left = draw_pause();
        end else begin
            if (drv_valid && cmd_bus.ready) begin
                sent = t_cmd_item'{drv_op, drv_opcode, drv_len, drv_tag};
                want = trie_apply(sent);
                rsp_expected.push_back(want);
                status_seen[want.status]++;
                if (sent.operation == optd_pkg::OP_ADD)
                    n_adds++;
                else
                    n_finds++;
                if (want.collision)
                    n_collisions++;
                if ($urandom_range(0, 39) == 0)
                    no_idle <= ~no_idle;
            end
            if (!(drv_valid && !cmd_bus.ready)) begin
                if (wait_left > 0) begin
                    wait_left--;
                    drv_valid <= 1'b0;
                end else if (cmd_backlog.size() > 0) begin
                    sent = cmd_backlog.pop_front();
                    drv_op     <= sent.operation;
                    drv_opcode <= sent.opcode;
                    drv_len    <= sent.prefix_length;
                    drv_tag    <= sent.handler_tag;
                    drv_valid  <= 1'b1;
                    wait_left = draw_pause();
                end else begin
                    drv_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: random back-pressure, compare each response with the oldest expectation
    always @(posedge i_clk) begin : monitor
        t_rsp_expect want;
        if (!i_rst_n) begin
            rsp_ready_q <= 1'b0;
            stall_left = 0;
        end else begin
            if (rsp_bus.valid && rsp_ready_q) begin
                n_rsp++;
                if (rsp_expected.size() == 0) begin
                    $error("response with nothing expected: status %0d tag %0d collision %0d",
                           rsp_bus.status, rsp_bus.found_tag, rsp_bus.collision);
                    n_errors++;
                end else begin
                    want = rsp_expected.pop_front();
                    if (rsp_bus.status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, rsp_bus.status);
                        n_errors++;
                    end
                    if (rsp_bus.found_tag !== want.found_tag) begin
                        $error("found_tag: expected %0d, actual %0d",
                               want.found_tag, rsp_bus.found_tag);
                        n_errors++;
                    end
                    if (rsp_bus.collision !== want.collision) begin
                        $error("collision: expected %0d, actual %0d",
                               want.collision, rsp_bus.collision);
                        n_errors++;
                    end
                end
                stall_left = draw_pause();
            end else if (stall_left > 0) begin
                stall_left--;
            end
            rsp_ready_q <= (stall_left == 0);
        end
    end

    initial begin
        root_made    = 1'b0;
        nodes_used   = 0;
        n_finds      = 0;
        n_adds       = 0;
        n_collisions = 0;
        n_errors     = 0;
        n_rsp        = 0;
        cycles       = 0;
        foreach (status_seen[i])
            status_seen[i] = 0;

        // directed part
        queue_cmd(optd_pkg::OP_FIND, 32'h0000_0000, 6'd0,  8'h00);  // empty table
        queue_cmd(optd_pkg::OP_FIND, 32'hFFFF_FFFF, 6'd63, 8'hFF);  // empty, ignored fields high
        queue_cmd(optd_pkg::OP_ADD,  32'h0000_0000, 6'd0,  8'h11);  // zero-length prefix
        queue_cmd(optd_pkg::OP_FIND, 32'h0000_0000, 6'd0,  8'h00);  // root without children
        queue_cmd(optd_pkg::OP_ADD,  32'h0000_0005, 6'd3,  8'hA5);
        queue_cmd(optd_pkg::OP_FIND, 32'hA000_0000, 6'd5,  8'h3C);
        queue_cmd(optd_pkg::OP_FIND, 32'h8000_0000, 6'd0,  8'h00);  // falls off the trie
        queue_cmd(optd_pkg::OP_ADD,  32'h0000_0001, 6'd1,  8'h00);  // tag zero on inner node
        queue_cmd(optd_pkg::OP_ADD,  32'h0000_0002, 6'd2,  8'h33);  // inner node, collision
        queue_cmd(optd_pkg::OP_FIND, 32'hA000_0000, 6'd0,  8'h00);  // shorter prefix wins
        queue_cmd(optd_pkg::OP_ADD,  32'h0000_0002, 6'd2,  8'h44);  // overwrite
        queue_cmd(optd_pkg::OP_FIND, 32'hBFFF_FFFF, 6'd0,  8'h00);
        queue_cmd(optd_pkg::OP_ADD,  32'h0000_0000, 6'd0,  8'hFF);  // root again, with children
        queue_cmd(optd_pkg::OP_ADD,  32'hFFFF_FFFF, 6'd32, 8'hFF);
        queue_cmd(optd_pkg::OP_FIND, 32'hFFFF_FFFF, 6'd0,  8'h00);
        queue_cmd(optd_pkg::OP_ADD,  32'h0000_0007, 6'd3,  8'h00);
        queue_cmd(optd_pkg::OP_FIND, 32'h7FFF_FFFF, 6'd0,  8'h00);
        queue_cmd(optd_pkg::OP_ADD,  32'hFFFF_FFFF, 6'd63, 8'h01);  // bits above word are zero
        queue_cmd(optd_pkg::OP_ADD,  32'h0000_0000, 6'd33, 8'h02);
        queue_cmd(optd_pkg::OP_FIND, 32'h0000_0000, 6'd0,  8'h00);  // no handler on the path
        queue_cmd(optd_pkg::OP_FIND, 32'h0000_0001, 6'd0,  8'h00);
        queue_cmd(optd_pkg::OP_ADD,  32'hFFFF_FFFE, 6'd32, 8'h5A);
        queue_cmd(optd_pkg::OP_FIND, 32'hFFFF_FFFE, 6'd0,  8'h00);
        queue_cmd(optd_pkg::OP_FIND, 32'h5555_5555, 6'd21, 8'hAA);

        build_random(RANDOM_ITEMS);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (!(cmd_backlog.size() == 0 && !drv_valid && rsp_expected.size() == 0)
               && cycles < LIMIT_CYCLES) begin
            @(negedge i_clk);
            cycles++;
        end
        if (cycles < LIMIT_CYCLES)
            repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (cycles >= LIMIT_CYCLES) begin
            $display("opcode_prefix_trie_decoder verification failed");
        end else begin
            $display("ran %0d finds and %0d adds over %0d cycles, %0d of %0d trie nodes used",
                     n_finds, n_adds, cycles, nodes_used, TRIE_NODES);
            $display("done %0d, empty %0d, unknown %0d, no handler %0d, pool full %0d",
                     status_seen[optd_pkg::ST_DONE], status_seen[optd_pkg::ST_EMPTY],
                     status_seen[optd_pkg::ST_UNKNOWN], status_seen[optd_pkg::ST_NO_HANDLER],
                     status_seen[optd_pkg::ST_POOL_FULL]);
            $display("adds that ended on a node with children: %0d", n_collisions);
            if (n_errors == 0 && rsp_expected.size() == 0)
                $display("opcode_prefix_trie_decoder verification clean");
            else
                $display("opcode_prefix_trie_decoder verification failed");
        end
        $finish;
    end

endmodule
